// ----- rtl/mvm_pkg.sv -----
// Package for the matrix-vector multiply engine.
// Holds sizes, request codes and the structs passed between the store, the MAC and the top.
// Depends on nothing.
package mvm_pkg;

    localparam int MAX_DIM    = 16;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int MAT_DEPTH  = 1 << ADDR_W;
    localparam int VEC_DEPTH  = 1 << IDX_W;
    localparam int SIZE_W     = 5;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    localparam logic [1:0] REQ_MAT = 2'd0;
    localparam logic [1:0] REQ_VEC = 2'd1;
    localparam logic [1:0] REQ_MUL = 2'd2;

    typedef struct packed {
        logic              mat_we;
        logic              vec_we;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] data;
    } t_store_wr;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_store_rd;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

// ----- rtl/mvm_if.sv -----
// Valid/ready channel interfaces for request words and result words.
// Depends on mvm_pkg for field widths.
interface mvm_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        req_type;
    logic [mvm_pkg::IDX_W-1:0]         row_index;
    logic [mvm_pkg::IDX_W-1:0]         col_index;
    logic signed [mvm_pkg::DATA_W-1:0] value;

    modport source (output valid, req_type, row_index, col_index, value, input ready);
    modport sink   (input valid, req_type, row_index, col_index, value, output ready);
endinterface

interface mvm_res_if;
    logic                              valid;
    logic                              ready;
    logic [mvm_pkg::IDX_W-1:0]         out_row;
    logic signed [mvm_pkg::DATA_W-1:0] product;
    logic                              last;
    logic                              index_error;

    modport source (output valid, out_row, product, last, index_error, input ready);
    modport sink   (input valid, out_row, product, last, index_error, output ready);
endinterface

// ----- rtl/mvm_store.sv -----
// Matrix and vector stores: synchronous memories, one write and one registered read each.
// Depends on mvm_pkg.
module mvm_store (
    input  logic                       i_clk,
    input  mvm_pkg::t_store_wr         i_wr,
    input  mvm_pkg::t_store_rd         i_rd,
    output logic [mvm_pkg::DATA_W-1:0] o_mat_q,
    output logic [mvm_pkg::DATA_W-1:0] o_vec_q
);
    import mvm_pkg::*;

    logic [DATA_W-1:0] r_mat_mem [MAT_DEPTH];
    logic [DATA_W-1:0] r_vec_mem [VEC_DEPTH];
    logic [DATA_W-1:0] r_mat_q;
    logic [DATA_W-1:0] r_vec_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.mat_we) begin
            r_mat_mem[{i_wr.row, i_wr.col}] <= i_wr.data;
        end
        r_mat_q <= r_mat_mem[{i_rd.row, i_rd.col}];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.vec_we) begin
            r_vec_mem[i_wr.row] <= i_wr.data;
        end
        r_vec_q <= r_vec_mem[i_rd.col];
    end

    assign o_mat_q = r_mat_q;
    assign o_vec_q = r_vec_q;

endmodule

// ----- rtl/mvm_mac.sv -----
// Multiply-accumulate unit: registered 32x32 product, saturating 64-bit sum,
// and rounding of the sum to saturated Q16.16. Depends on mvm_pkg.
module mvm_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mvm_pkg::t_mac_ctl                 i_ctl,
    input  logic [mvm_pkg::DATA_W-1:0]        i_mat,
    input  logic [mvm_pkg::DATA_W-1:0]        i_vec,
    output logic                              o_done,
    output logic signed [mvm_pkg::DATA_W-1:0] o_product
);
    import mvm_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] RND_LIM  = ACC_MAX - HALF_LSB;
    localparam int                      Q_W      = ACC_W - 16;

    logic signed [ACC_W-1:0] r_prod;
    t_mac_ctl                r_pctl;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_done;

    logic signed [ACC_W-1:0] w_base;
    logic signed [ACC_W:0]   w_sum;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [Q_W-1:0]   w_q;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_mat) * $signed(i_vec);
    end

    // Restart the sum on the first column of each row.
    always_comb begin
        w_base = r_pctl.first ? '0 : r_acc;
        w_sum  = {w_base[ACC_W-1], w_base} + {r_prod[ACC_W-1], r_prod};
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            n_acc = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_acc = w_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pctl <= '0;
            r_acc  <= '0;
            r_done <= 1'b0;
        end else begin
            r_pctl <= i_ctl;
            r_done <= r_pctl.valid && r_pctl.last;
            if (r_pctl.valid) begin
                r_acc <= n_acc;
            end
        end
    end

    // Round half up, then floor shift and clamp to 32 bits.
    always_comb begin
        w_rnd = r_acc + HALF_LSB;
        w_q   = w_rnd[ACC_W-1:16];
        if (r_acc > RND_LIM) begin
            o_product = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (w_q[Q_W-1:DATA_W-1] != {(Q_W-DATA_W+1){w_q[Q_W-1]}}) begin
            o_product = w_q[Q_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            o_product = w_q[DATA_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// ----- rtl/matrix_vector_multiply_top.sv -----
// Top level of the matrix-vector multiply engine: request decode, row/column
// sequencer, size register and result register. Depends on mvm_pkg, mvm_if, mvm_store, mvm_mac.
//
//   channel   dir  handshake     word
//   i_req     in   valid/ready   req_type, row_index, col_index, value
//   o_res     out  valid/ready   out_row, product, last, index_error
//   cfg       in   i_cfg_we      i_cfg_data = matrix_size
//
// A compute runs row by row, one column at a time, through the single MAC and
// the one read port of each store.
// Reset (synchronous, active low) sets the size to 16 and empties the result
// register; store contents are undefined until written.
// Requests stall while a compute runs, and while the result register is full
// and not being taken; a stalled result holds the sequencer in its emit step.
module matrix_vector_multiply_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mvm_pkg::SIZE_W-1:0]   i_cfg_data,
    mvm_req_if.sink                      i_req,
    mvm_res_if.source                    o_res
);
    import mvm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state             r_state,   n_state;
    logic [IDX_W-1:0]   r_row,     n_row;
    logic [IDX_W-1:0]   r_col,     n_col;
    t_mac_ctl           r_iss,     n_iss;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_out_row,   n_out_row;
    logic [DATA_W-1:0]  r_out_prod,  n_out_prod;
    logic               r_out_last,  n_out_last;
    logic               r_out_err,   n_out_err;
    logic [SIZE_W-1:0]  r_size;

    logic [SIZE_W-1:0]  w_n;
    logic [SIZE_W-1:0]  w_nm1;
    logic               w_acc;
    logic               w_bad;
    logic               w_out_free;
    logic               w_col_last;
    logic               w_row_last;
    logic               w_done;
    logic signed [DATA_W-1:0] w_product;
    logic [DATA_W-1:0]  w_mat_q;
    logic [DATA_W-1:0]  w_vec_q;
    t_store_wr          w_wr;
    t_store_rd          w_rd;

    // Active size clamped to 1..MAX_DIM.
    always_comb begin
        if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_DIM)) begin
            w_n = SIZE_W'(MAX_DIM);
        end else begin
            w_n = r_size;
        end
    end

    assign w_nm1      = w_n - SIZE_W'(1);
    assign w_col_last = ({1'b0, r_col} == w_nm1);
    assign w_row_last = ({1'b0, r_row} == w_nm1);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc      = i_req.valid && i_req.ready;
    assign w_bad      = ({1'b0, i_req.row_index} >= w_n)
                     || ((i_req.req_type == REQ_MAT) && ({1'b0, i_req.col_index} >= w_n));

    always_comb begin
        w_wr.mat_we = w_acc && (i_req.req_type == REQ_MAT) && !w_bad;
        w_wr.vec_we = w_acc && (i_req.req_type == REQ_VEC) && !w_bad;
        w_wr.row    = i_req.row_index;
        w_wr.col    = i_req.col_index;
        w_wr.data   = i_req.value;
        w_rd.row    = r_row;
        w_rd.col    = r_col;
    end

    mvm_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .o_mat_q (w_mat_q),
        .o_vec_q (w_vec_q)
    );

    mvm_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (r_iss),
        .i_mat     (w_mat_q),
        .i_vec     (w_vec_q),
        .o_done    (w_done),
        .o_product (w_product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_iss       = '0;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_row   = r_out_row;
        n_out_prod  = r_out_prod;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_req.req_type) inside
                        REQ_MAT, REQ_VEC: begin
                            if (w_bad) begin
                                n_out_valid = 1'b1;
                                n_out_row   = i_req.row_index;
                                n_out_prod  = '0;
                                n_out_last  = 1'b0;
                                n_out_err   = 1'b1;
                            end
                        end
                        REQ_MUL: begin
                            n_state = S_RUN;
                            n_row   = '0;
                            n_col   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                n_iss.valid = 1'b1;
                n_iss.first = (r_col == '0);
                n_iss.last  = w_col_last;
                if (w_col_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (w_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Hold the finished row until the result register frees up.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_row;
                    n_out_prod  = w_product;
                    n_out_last  = w_row_last;
                    n_out_err   = 1'b0;
                    n_col       = '0;
                    if (w_row_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + IDX_W'(1);
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_iss       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_iss       <= n_iss;
            r_out_valid <= n_out_valid;
        end
        r_out_row  <= n_out_row;
        r_out_prod <= n_out_prod;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_row     = r_out_row;
    assign o_res.product     = r_out_prod;
    assign o_res.last        = r_out_last;
    assign o_res.index_error = r_out_err;

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.index_error) |-> (o_res.product == '0) && !o_res.last)
        else $error("error word carries a product or last flag");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.index_error) |-> ({1'b0, o_res.out_row} < w_n))
        else $error("product row beyond active size");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> ({1'b0, o_res.out_row} == w_nm1))
        else $error("last flag on a row other than the final one");

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_DRAIN))
        else $error("MAC finished a row outside the drain step");

endmodule

// ----- tb/sv/matrix_vector_multiply_top_tb.sv -----
// Testbench for matrix_vector_multiply_top: a directed table, then random load/compute phases
// at several sizes, words checked vs a typed row's word or a Q16.16 row-dot-vector predictor.
// Depends on mvm_pkg, the mvm_req_if/mvm_res_if interfaces and the RTL top level.
module matrix_vector_multiply_top_tb;
    import mvm_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CFG_SETTLE      = 8;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int NUM_DIRECTED    = 25;
    localparam int NUM_PHASES      = 6;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [1:0]        kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              typed;
        logic [IDX_W-1:0]  exp_row;
        logic [DATA_W-1:0] exp_product;
        logic              exp_last;
        logic              exp_error;
    } t_req_word;

    typedef struct packed {
        logic [IDX_W-1:0]  out_row;
        logic [DATA_W-1:0] product;
        logic              last;
        logic              index_error;
    } t_res_word;

    // size, kind, row, col, value, typed, expected out_row, product, last, index_error
    t_req_word directed_rows [NUM_DIRECTED] = '{
        '{5'd16, REQ_MAT,    4'd15, 4'd15, Q_MAX,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd16, REQ_UNUSED, 4'd0,  4'd0,  32'h1234_5678, 1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd1,  REQ_UNUSED, 4'd15, 4'd15, Q_MIN,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd1,  REQ_MAT,    4'd0,  4'd0,  Q_MAX,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd1,  REQ_VEC,    4'd0,  4'd0,  Q_MAX,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd1,  REQ_MUL,    4'd0,  4'd0,  32'd0,         1'b1, 4'd0,  Q_MAX,         1'b1, 1'b0},
        '{5'd1,  REQ_MAT,    4'd1,  4'd0,  Q_ONE,         1'b1, 4'd1,  32'd0,         1'b0, 1'b1},
        '{5'd1,  REQ_MAT,    4'd0,  4'd15, Q_ONE,         1'b1, 4'd0,  32'd0,         1'b0, 1'b1},
        '{5'd1,  REQ_VEC,    4'd15, 4'd0,  Q_ONE,         1'b1, 4'd15, 32'd0,         1'b0, 1'b1},
        '{5'd1,  REQ_MAT,    4'd0,  4'd0,  Q_MIN,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd1,  REQ_MUL,    4'd0,  4'd0,  32'd0,         1'b1, 4'd0,  Q_MIN,         1'b1, 1'b0},
        '{5'd1,  REQ_VEC,    4'd0,  4'd0,  Q_MIN,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd1,  REQ_MUL,    4'd0,  4'd0,  32'd0,         1'b1, 4'd0,  Q_MAX,         1'b1, 1'b0},
        '{5'd0,  REQ_MAT,    4'd1,  4'd1,  Q_MIN,         1'b1, 4'd1,  32'd0,         1'b0, 1'b1},
        '{5'd0,  REQ_MAT,    4'd0,  4'd0,  Q_ONE,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd0,  REQ_VEC,    4'd0,  4'd0,  32'h0001_8000, 1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd0,  REQ_MUL,    4'd0,  4'd0,  32'd0,         1'b1, 4'd0,  32'h0001_8000, 1'b1, 1'b0},
        '{5'd0,  REQ_VEC,    4'd0,  4'd0,  32'hFFFF_FFFF, 1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd0,  REQ_MUL,    4'd0,  4'd0,  32'd0,         1'b1, 4'd0,  32'hFFFF_FFFF, 1'b1, 1'b0},
        '{5'd2,  REQ_MAT,    4'd0,  4'd1,  32'h0002_0000, 1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd2,  REQ_MAT,    4'd1,  4'd0,  32'hFFFF_0000, 1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd2,  REQ_MAT,    4'd1,  4'd1,  Q_MAX,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd2,  REQ_VEC,    4'd1,  4'd0,  Q_MIN,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd2,  REQ_MUL,    4'd0,  4'd0,  32'd0,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0},
        '{5'd31, REQ_VEC,    4'd15, 4'd0,  Q_MIN,         1'b0, 4'd0,  32'd0,         1'b0, 1'b0}
    };

    logic [SIZE_W-1:0] phase_sizes [NUM_PHASES] = '{5'd2, 5'd1, 5'd4, 5'd3, 5'd0, 5'd5};

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_data;

    mvm_req_if req_ch ();
    mvm_res_if res_ch ();

    matrix_vector_multiply_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    // predictor state, updated on accepted words
    logic [DATA_W-1:0] matrix_copy [MAX_DIM][MAX_DIM];
    logic [DATA_W-1:0] vector_copy [MAX_DIM];
    logic [SIZE_W-1:0] size_copy;
    t_res_word         product_queue [$];
    t_req_word         sent_queue [$];

    // stimulus side: which entries hold data, so a compute never reads an empty one
    bit                mat_loaded [MAX_DIM][MAX_DIM];
    bit                vec_loaded [MAX_DIM];
    logic [SIZE_W-1:0] size_now;

    int mismatches   = 0;
    int cycles       = 0;
    bit quiet        = 1'b0;
    bit hold_results = 1'b0;

    function automatic int active_dim(input logic [SIZE_W-1:0] size);
        if (size == 0) return 1;
        if (size > MAX_DIM) return MAX_DIM;
        return int'(size);
    endfunction

    function automatic logic [DATA_W-1:0] row_dot(input int r, input int n);
        longint              acc;
        longint              term;
        longint              q;
        logic signed [ACC_W:0] sum;
        acc = 0;
        for (int j = 0; j < n; j++) begin
            term = longint'($signed(matrix_copy[r][j])) * longint'($signed(vector_copy[j]));
            sum = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
            // clamp the running sum at the 64-bit limits
            if (sum[ACC_W:ACC_W-1] == 2'b01) acc = 64'h7FFF_FFFF_FFFF_FFFF;
            else if (sum[ACC_W:ACC_W-1] == 2'b10) acc = 64'h8000_0000_0000_0000;
            else acc = sum[ACC_W-1:0];
        end
        if (acc > 64'sh7FFF_FFFF_FFFF_7FFF) return Q_MAX;
        q = (acc + 64'sd32768) >>> 16;
        if (q > 64'sd2147483647) return Q_MAX;
        if (q < -64'sd2147483648) return Q_MIN;
        return q[DATA_W-1:0];
    endfunction

    function automatic void expect_word(input t_req_word plan, input t_res_word word);
        if (plan.typed) begin
            product_queue.push_back({plan.exp_row, plan.exp_product, plan.exp_last, plan.exp_error});
        end else begin
            product_queue.push_back(word);
        end
    endfunction

    function automatic bit entry_loaded(input int slot, input int n);
        if (slot < n * n) return mat_loaded[slot / n][slot % n];
        return vec_loaded[slot - n * n];
    endfunction

    function automatic bit all_loaded(input int n);
        for (int s = 0; s < n * n + n; s++) begin
            if (!entry_loaded(s, n)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int draw_wait();
        if (quiet) return 0;
        return int'($urandom_range(0, 10));
    endfunction

    function automatic logic [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            4: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic offer_request(input t_req_word item);
        int gap;
        int n;
        gap = draw_wait();
        n = active_dim(size_now);
        if (item.kind == REQ_MAT && item.row < n && item.col < n) mat_loaded[item.row][item.col] = 1'b1;
        if (item.kind == REQ_VEC && item.row < n) vec_loaded[item.row] = 1'b1;
        sent_queue.push_back(item);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= item.kind;
        req_ch.row_index <= item.row;
        req_ch.col_index <= item.col;
        req_ch.value     <= item.value;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] size);
        if (size != size_now) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while (product_queue.size() != 0) @(posedge i_clk);
            // let a trailing load settle before touching the size
            repeat (CFG_SETTLE) @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_data <= size;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            size_now = size;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin : predict
        t_req_word plan;
        int        n;
        if (!i_rst_n) begin
            size_copy = SIZE_RESET;
        end else if (i_cfg_we) begin
            size_copy = i_cfg_data;
        end else if (req_ch.valid && req_ch.ready) begin
            plan = sent_queue.pop_front();
            n = active_dim(size_copy);
            if (req_ch.req_type == REQ_MAT || req_ch.req_type == REQ_VEC) begin
                if (req_ch.row_index >= n || (req_ch.req_type == REQ_MAT && req_ch.col_index >= n)) begin
                    expect_word(plan, {req_ch.row_index, 32'd0, 1'b0, 1'b1});
                end else if (req_ch.req_type == REQ_MAT) begin
                    matrix_copy[req_ch.row_index][req_ch.col_index] = req_ch.value;
                end else begin
                    vector_copy[req_ch.row_index] = req_ch.value;
                end
            end else if (req_ch.req_type == REQ_MUL) begin
                for (int i = 0; i < n; i++) begin
                    expect_word(plan, {IDX_W'(i), row_dot(i, n), i == n - 1, 1'b0});
                end
            end
        end
    end

    always @(posedge i_clk) begin : check
        t_res_word want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (product_queue.size() == 0) begin
                report_mismatch($sformatf("word with none awaited, row %0d product %h",
                                          res_ch.out_row, res_ch.product));
            end else begin
                want = product_queue.pop_front();
                if (res_ch.out_row !== want.out_row)
                    report_mismatch($sformatf("out_row want %0d got %0d", want.out_row, res_ch.out_row));
                if (res_ch.product !== want.product)
                    report_mismatch($sformatf("row %0d product want %h got %h",
                                              want.out_row, want.product, res_ch.product));
                if (res_ch.last !== want.last)
                    report_mismatch($sformatf("row %0d last want %b got %b",
                                              want.out_row, want.last, res_ch.last));
                if (res_ch.index_error !== want.index_error)
                    report_mismatch($sformatf("row %0d index_error want %b got %b",
                                              want.out_row, want.index_error, res_ch.index_error));
            end
        end
    end

    initial begin : receiver
        int hold;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                hold = HOLD_OFF_CYCLES;
            end else begin
                hold = draw_wait();
            end
            if (hold > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    initial begin : stimulus
        t_req_word item;
        int        n;
        int        computes;
        int        goal;
        int        pick;
        int        slot;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_data       <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_MAT;
        req_ch.row_index <= '0;
        req_ch.col_index <= '0;
        req_ch.value     <= '0;
        size_now = SIZE_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_DIRECTED; k++) begin
            set_size(directed_rows[k].size);
            offer_request(directed_rows[k]);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_size(phase_sizes[phase]);
            quiet = (phase % 3 == 2);
            if (phase == 2) hold_results = 1'b1;
            n = active_dim(size_now);
            computes = 0;
            goal = (n == MAX_DIM) ? 2 : 4;
            while (computes < goal) begin
                item = '0;
                pick = int'($urandom_range(0, 99));
                if (pick < 10 && n < MAX_DIM) begin
                    // out-of-range load on row or column
                    item.kind = $urandom_range(0, 1) ? REQ_VEC : REQ_MAT;
                    item.row = IDX_W'($urandom_range(0, MAX_DIM - 1));
                    item.col = IDX_W'($urandom_range(0, MAX_DIM - 1));
                    if (item.kind == REQ_VEC || $urandom_range(0, 1))
                        item.row = IDX_W'($urandom_range(n, MAX_DIM - 1));
                    else
                        item.col = IDX_W'($urandom_range(n, MAX_DIM - 1));
                end else if (pick < 15) begin
                    item.kind = REQ_UNUSED;
                    item.row = IDX_W'($urandom_range(0, MAX_DIM - 1));
                    item.col = IDX_W'($urandom_range(0, MAX_DIM - 1));
                end else if (pick < 40 && all_loaded(n)) begin
                    item.kind = REQ_MUL;
                    item.row = IDX_W'($urandom_range(0, MAX_DIM - 1));
                    item.col = IDX_W'($urandom_range(0, MAX_DIM - 1));
                    computes++;
                end else begin
                    // fill empty entries first, then overwrite at random
                    slot = int'($urandom_range(0, n * n + n - 1));
                    if (!all_loaded(n)) begin
                        while (entry_loaded(slot, n)) slot = (slot + 1) % (n * n + n);
                    end
                    if (slot < n * n) begin
                        item.kind = REQ_MAT;
                        item.row = IDX_W'(slot / n);
                        item.col = IDX_W'(slot % n);
                    end else begin
                        item.kind = REQ_VEC;
                        item.row = IDX_W'(slot - n * n);
                        item.col = IDX_W'($urandom_range(0, MAX_DIM - 1));
                    end
                end
                item.value = draw_value();
                offer_request(item);
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (product_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
